### hw/rtl/mm3_pkg.sv
// ----------------------------------------------------------------------------
// mm3_pkg
// shared types, constants and helper functions for the murmur3 x64_128 engine
// ----------------------------------------------------------------------------
package mm3_pkg;

   localparam logic [63:0] MIX_C1     = 64'h87c37b91114253d5;
   localparam logic [63:0] MIX_C2     = 64'h4cf5ad432745937f;
   localparam logic [63:0] LANE1_ADD  = 64'h0000000052dce729;
   localparam logic [63:0] LANE2_ADD  = 64'h0000000038495ab5;
   localparam logic [63:0] FIN_M1     = 64'hff51afd7ed558ccd;
   localparam logic [63:0] FIN_M2     = 64'hc4ceb9fe1a85ec53;
   localparam logic [31:0] SEED_RESET = 32'h4e55436c;

   localparam logic [4:0] BLOCK_BYTES = 5'd16;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_B1_PART,
      ST_B1_SUM,
      ST_B2_PART,
      ST_B2_SUM,
      ST_LANE_ONE,
      ST_LANE_TWO,
      ST_TAIL,
      ST_FIN_PREP,
      ST_FIN_FOLD,
      ST_F1_PART,
      ST_F1_SUM,
      ST_F2_PART,
      ST_F2_SUM,
      ST_FIN_ADD,
      ST_FIN_OUT
   } state_type;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_LOAD,
      OP_MUL_PART,
      OP_MUL_SUM,
      OP_LANE_ONE,
      OP_LANE_TWO,
      OP_TAIL,
      OP_FIN_PREP,
      OP_FIN_FOLD,
      OP_FIN_ADD,
      OP_FIN_OUT
   } op_type;

   typedef enum logic [1:0] {
      CSEL_BODY_ONE,
      CSEL_BODY_TWO,
      CSEL_FIN_ONE,
      CSEL_FIN_TWO
   } csel_type;

   typedef enum logic [1:0] {
      WB_ROTATE,
      WB_PLAIN,
      WB_FOLD
   } wb_type;

   typedef struct packed {
      op_type   op;
      csel_type csel;
      wb_type   wb;
   } cmd_type;

   typedef struct packed {
      logic last;
      logic full;
      logic out_busy;
   } status_type;

   function automatic logic [63:0] rotl64(input logic [63:0] v, input int unsigned n);
      return (v << n) | (v >> (64 - n));
   endfunction

   // keeps the low count bytes of a word, count 0 to 8
   function automatic logic [63:0] byte_mask(input logic [3:0] count);
      logic [63:0] m;
      if (count >= 4'd8) begin
         m = '1;
      end else begin
         m = (64'd1 << {count[2:0], 3'b000}) - 64'd1;
      end
      return m;
   endfunction

   function automatic logic [63:0] fold33(input logic [63:0] v);
      return v ^ (v >> 33);
   endfunction

endpackage

### hw/rtl/mm3_req_if.sv
// ----------------------------------------------------------------------------
// mm3_req_if
// block channel into the hash engine: two 64-bit words, byte count, last flag
// ----------------------------------------------------------------------------
interface mm3_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] low_word;
   logic [63:0] high_word;
   logic [4:0]  valid_bytes;
   logic        is_last;

   modport source (output valid, low_word, high_word, valid_bytes, is_last, input ready);
   modport sink   (input valid, low_word, high_word, valid_bytes, is_last, output ready);
endinterface

### hw/rtl/mm3_rsp_if.sv
// ----------------------------------------------------------------------------
// mm3_rsp_if
// result channel out of the hash engine: 128-bit hash as two 64-bit halves
// ----------------------------------------------------------------------------
interface mm3_rsp_if;
   logic        valid;
   logic        ready;
   logic [63:0] hash_low;
   logic [63:0] hash_high;

   modport source (output valid, hash_low, hash_high, input ready);
   modport sink   (input valid, hash_low, hash_high, output ready);
endinterface

### hw/rtl/murmur3_x64_128_hash.sv
// ----------------------------------------------------------------------------
// murmur3_x64_128_hash
// streaming murmurhash3 x64_128 engine with a programmable 32-bit seed
// ----------------------------------------------------------------------------
// A message enters as 16-byte words on req (low_word = bytes 0..7, high_word
// = bytes 8..15, little endian) with valid_bytes and is_last; every word that
// is not last is mixed as a full 16 bytes. The last word may carry 0 to 16
// bytes (counts above 16 mean 16); its trailing bytes are ignored. After the
// last word the 128-bit hash appears on rsp (hash_low = h1, hash_high = h2)
// and the engine rearms with the seed for the next message. One word is worked
// on at a time: no new word is accepted until the engine is through with the
// last one. The work runs through the two 64-bit multipliers, each split into
// a partial-product step and a sum step, used twice for the body mix and twice
// more for the finalizer, with the lane, tail and fold steps between. A
// finished hash waits in an output register, so the next message can start
// while it is still unread; a second finished hash holds in the final step,
// with the input not ready, until the first one is taken. Writing
// csr_write_data with csr_write_enable loads a new seed and restarts the
// message; write it only while the engine is idle.
// ----------------------------------------------------------------------------
module murmur3_x64_128_hash import mm3_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   mm3_req_if.sink     req,
   mm3_rsp_if.source   rsp,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data
);

   cmd_type    cmd;
   status_type status;

   // sequencer: owns the req handshake; one op per cycle, held on a full result
   mm3_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // datapath: lanes, length, scramble words, multipliers, result word
   mm3_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .low_word         (req.low_word),
      .high_word        (req.high_word),
      .valid_bytes      (req.valid_bytes),
      .is_last          (req.is_last),
      .rsp_valid        (rsp.valid),
      .rsp_ready        (rsp.ready),
      .hash_low         (rsp.hash_low),
      .hash_high        (rsp.hash_high)
   );

   // a word is loaded only on a real handshake
   a_load_on_accept: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_LOAD) |-> (req.valid && req.ready))
      else $error("datapath load without an accepted word");

   // one word at a time: no accept right after an accept
   a_no_back_to_back: assert property (@(posedge clock) disable iff (reset)
      (req.valid && req.ready) |=> !req.ready)
      else $error("word accepted while the previous one is in work");

   // a finished hash never overwrites a result still waiting
   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_FIN_OUT) |-> !(rsp.valid && !rsp.ready))
      else $error("result register overwritten while full");

   // the output only becomes valid from the final step
   a_result_from_final: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp.valid) |-> $past(cmd.op == OP_FIN_OUT))
      else $error("result appeared without a finished hash");

endmodule

### hw/rtl/mm3_mul64.sv
// ----------------------------------------------------------------------------
// mm3_mul64
// 64x64 multiplier with registered partial products, low 64 bits of the product only
// ----------------------------------------------------------------------------
module mm3_mul64 (
   input  logic        clock,
   input  logic        part_en,
   input  logic [63:0] a,
   input  logic [63:0] b,
   output logic [63:0] product
);

   logic [63:0] ll_in, ll_ff;
   logic [31:0] lh_in, lh_ff;
   logic [31:0] hl_in, hl_ff;

   // cross products only contribute their low halves
   assign ll_in = {32'h0, a[31:0]} * {32'h0, b[31:0]};
   assign lh_in = a[31:0] * b[63:32];
   assign hl_in = a[63:32] * b[31:0];

   always_ff @(posedge clock) begin
      if (part_en) begin
         ll_ff <= ll_in;
         lh_ff <= lh_in;
         hl_ff <= hl_in;
      end
   end

   assign product = ll_ff + {lh_ff + hl_ff, 32'h0};

endmodule

### hw/rtl/mm3_ctrl.sv
// ----------------------------------------------------------------------------
// mm3_ctrl
// sequencer: steps the datapath through body, tail and finalizer operations
// ----------------------------------------------------------------------------
module mm3_ctrl import mm3_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:     if (req_valid) state_in = ST_B1_PART;
         ST_B1_PART:  state_in = ST_B1_SUM;
         ST_B1_SUM:   state_in = ST_B2_PART;
         ST_B2_PART:  state_in = ST_B2_SUM;
         ST_B2_SUM:   state_in = status.full ? ST_LANE_ONE : ST_TAIL;
         ST_LANE_ONE: state_in = ST_LANE_TWO;
         ST_LANE_TWO: state_in = status.last ? ST_FIN_PREP : ST_IDLE;
         ST_TAIL:     state_in = ST_FIN_PREP;
         ST_FIN_PREP: state_in = ST_FIN_FOLD;
         ST_FIN_FOLD: state_in = ST_F1_PART;
         ST_F1_PART:  state_in = ST_F1_SUM;
         ST_F1_SUM:   state_in = ST_F2_PART;
         ST_F2_PART:  state_in = ST_F2_SUM;
         ST_F2_SUM:   state_in = ST_FIN_ADD;
         ST_FIN_ADD:  state_in = ST_FIN_OUT;
         ST_FIN_OUT:  if (!status.out_busy) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready = 1'b0;
      cmd.op    = OP_NONE;
      cmd.csel  = CSEL_BODY_ONE;
      cmd.wb    = WB_PLAIN;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) cmd.op = OP_LOAD;
         end
         ST_B1_PART: begin
            cmd.op   = OP_MUL_PART;
            cmd.csel = CSEL_BODY_ONE;
         end
         ST_B1_SUM: begin
            cmd.op = OP_MUL_SUM;
            cmd.wb = WB_ROTATE;
         end
         ST_B2_PART: begin
            cmd.op   = OP_MUL_PART;
            cmd.csel = CSEL_BODY_TWO;
         end
         ST_B2_SUM: begin
            cmd.op = OP_MUL_SUM;
            cmd.wb = WB_PLAIN;
         end
         ST_LANE_ONE: cmd.op = OP_LANE_ONE;
         ST_LANE_TWO: cmd.op = OP_LANE_TWO;
         ST_TAIL:     cmd.op = OP_TAIL;
         ST_FIN_PREP: cmd.op = OP_FIN_PREP;
         ST_FIN_FOLD: cmd.op = OP_FIN_FOLD;
         ST_F1_PART: begin
            cmd.op   = OP_MUL_PART;
            cmd.csel = CSEL_FIN_ONE;
         end
         ST_F1_SUM: begin
            cmd.op = OP_MUL_SUM;
            cmd.wb = WB_FOLD;
         end
         ST_F2_PART: begin
            cmd.op   = OP_MUL_PART;
            cmd.csel = CSEL_FIN_TWO;
         end
         ST_F2_SUM: begin
            cmd.op = OP_MUL_SUM;
            cmd.wb = WB_FOLD;
         end
         ST_FIN_ADD:  cmd.op = OP_FIN_ADD;
         ST_FIN_OUT:  if (!status.out_busy) cmd.op = OP_FIN_OUT;
         default:     cmd.op = OP_NONE;
      endcase
   end

endmodule

### hw/rtl/mm3_dp.sv
// ----------------------------------------------------------------------------
// mm3_dp
// datapath: hash lanes, byte total, scramble registers, two multipliers,
// result register
// ----------------------------------------------------------------------------
module mm3_dp import mm3_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  status,
   input  logic        csr_write_enable,
   input  logic [31:0] csr_write_data,
   input  logic [63:0] low_word,
   input  logic [63:0] high_word,
   input  logic [4:0]  valid_bytes,
   input  logic        is_last,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] hash_low,
   output logic [63:0] hash_high
);

   logic [31:0] seed_ff, seed_in;
   logic [63:0] lane_one_ff, lane_one_in;
   logic [63:0] lane_two_ff, lane_two_in;
   logic [63:0] total_ff, total_in;
   logic [63:0] k1_ff, k1_in;
   logic [63:0] k2_ff, k2_in;
   logic        last_ff, last_in;
   logic        full_ff, full_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [63:0] hash_low_ff, hash_low_in;
   logic [63:0] hash_high_ff, hash_high_in;

   logic [63:0] const_one, const_two;
   logic [63:0] prod_one, prod_two;
   logic [4:0]  n_eff;
   logic        full_blk;
   logic [3:0]  lo_cnt, hi_cnt;
   logic [63:0] mix_one, mix_two;
   logic [63:0] fin_one, fin_two, fin_sum;

   always_comb begin
      case (cmd.csel)
         CSEL_BODY_ONE: begin const_one = MIX_C1; const_two = MIX_C2; end
         CSEL_BODY_TWO: begin const_one = MIX_C2; const_two = MIX_C1; end
         CSEL_FIN_ONE:  begin const_one = FIN_M1; const_two = FIN_M1; end
         default:       begin const_one = FIN_M2; const_two = FIN_M2; end
      endcase
   end

   mm3_mul64 u_mul_one (
      .clock   (clock),
      .part_en (cmd.op == OP_MUL_PART),
      .a       (k1_ff),
      .b       (const_one),
      .product (prod_one)
   );

   mm3_mul64 u_mul_two (
      .clock   (clock),
      .part_en (cmd.op == OP_MUL_PART),
      .a       (k2_ff),
      .b       (const_two),
      .product (prod_two)
   );

   // byte count handling for the incoming word
   assign n_eff    = valid_bytes[4] ? BLOCK_BYTES : valid_bytes;
   assign full_blk = !is_last || valid_bytes[4];
   assign lo_cnt   = (full_blk || n_eff >= 5'd8) ? 4'd8 : n_eff[3:0];
   assign hi_cnt   = full_blk ? 4'd8 : ((n_eff > 5'd8) ? 4'(n_eff - 5'd8) : 4'd0);

   // lane rounds, x*5 as shift and add
   assign mix_one = rotl64(lane_one_ff ^ k1_ff, 27) + lane_two_ff;
   assign mix_two = rotl64(lane_two_ff ^ k2_ff, 31) + lane_one_ff;

   assign fin_one = lane_one_ff ^ total_ff;
   assign fin_two = lane_two_ff ^ total_ff;
   assign fin_sum = lane_one_ff + lane_two_ff;

   always_comb begin
      seed_in      = seed_ff;
      lane_one_in  = lane_one_ff;
      lane_two_in  = lane_two_ff;
      total_in     = total_ff;
      k1_in        = k1_ff;
      k2_in        = k2_ff;
      last_in      = last_ff;
      full_in      = full_ff;
      hash_low_in  = hash_low_ff;
      hash_high_in = hash_high_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      if (csr_write_enable) begin
         seed_in     = csr_write_data;
         lane_one_in = {32'h0, csr_write_data};
         lane_two_in = {32'h0, csr_write_data};
         total_in    = '0;
      end else begin
         case (cmd.op)
            OP_LOAD: begin
               k1_in    = low_word & byte_mask(lo_cnt);
               k2_in    = high_word & byte_mask(hi_cnt);
               last_in  = is_last;
               full_in  = full_blk;
               total_in = total_ff + (is_last ? {59'h0, n_eff} : {59'h0, BLOCK_BYTES});
            end
            OP_MUL_SUM: begin
               case (cmd.wb)
                  WB_ROTATE: begin
                     k1_in = rotl64(prod_one, 31);
                     k2_in = rotl64(prod_two, 33);
                  end
                  WB_FOLD: begin
                     k1_in = fold33(prod_one);
                     k2_in = fold33(prod_two);
                  end
                  default: begin
                     k1_in = prod_one;
                     k2_in = prod_two;
                  end
               endcase
            end
            OP_LANE_ONE: lane_one_in = (mix_one << 2) + mix_one + LANE1_ADD;
            OP_LANE_TWO: lane_two_in = (mix_two << 2) + mix_two + LANE2_ADD;
            OP_TAIL: begin
               // short last word: scrambles xor in without the lane round
               lane_one_in = lane_one_ff ^ k1_ff;
               lane_two_in = lane_two_ff ^ k2_ff;
            end
            OP_FIN_PREP: begin
               lane_one_in = fin_one + fin_two;
               lane_two_in = fin_two;
            end
            OP_FIN_FOLD: begin
               lane_two_in = fin_sum;
               k1_in       = fold33(lane_one_ff);
               k2_in       = fold33(fin_sum);
            end
            OP_FIN_ADD: begin
               lane_one_in = k1_ff + k2_ff;
               lane_two_in = k2_ff;
            end
            OP_FIN_OUT: begin
               hash_low_in  = lane_one_ff;
               hash_high_in = fin_sum;
               rsp_valid_in = 1'b1;
               lane_one_in  = {32'h0, seed_ff};
               lane_two_in  = {32'h0, seed_ff};
               total_in     = '0;
            end
            default: begin
               k1_in = k1_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff      <= SEED_RESET;
         lane_one_ff  <= {32'h0, SEED_RESET};
         lane_two_ff  <= {32'h0, SEED_RESET};
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         seed_ff      <= seed_in;
         lane_one_ff  <= lane_one_in;
         lane_two_ff  <= lane_two_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k1_ff        <= k1_in;
      k2_ff        <= k2_in;
      last_ff      <= last_in;
      full_ff      <= full_in;
      hash_low_ff  <= hash_low_in;
      hash_high_ff <= hash_high_in;
   end

   assign status.last     = last_ff;
   assign status.full     = full_ff;
   assign status.out_busy = rsp_valid_ff && !rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign hash_low  = hash_low_ff;
   assign hash_high = hash_high_ff;

endmodule
